// ===== rtl/ftss_pkg.sv =====
package ftss_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_TILE_MIN_X = 3'd0,
    REG_TILE_MIN_Y = 3'd1,
    REG_TILE_MAX_X = 3'd2,
    REG_TILE_MAX_Y = 3'd3,
    REG_RADIUS_X   = 3'd4,
    REG_RADIUS_Y   = 3'd5,
    REG_INV_RAD_X  = 3'd6,
    REG_INV_RAD_Y  = 3'd7
  } reg_idx_t;

  localparam int ACC_W   = 48;
  localparam int WSUM_W  = 32;
  localparam int TDEPTH  = 256;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         table_index;
    logic signed [15:0] table_weight;
    logic [19:0]        sample_x;
    logic [19:0]        sample_y;
    logic [15:0]        radiance_r;
    logic [15:0]        radiance_g;
    logic [15:0]        radiance_b;
    logic [15:0]        importance_r;
    logic [15:0]        importance_g;
    logic [15:0]        importance_b;
    logic [9:0]         read_index;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] sum_red;
    logic signed [47:0] sum_green;
    logic signed [47:0] sum_blue;
    logic signed [31:0] weight_total;
  } out_word_t;

  typedef struct packed {
    logic [ACC_W-1:0] r;
    logic [ACC_W-1:0] g;
    logic [ACC_W-1:0] b;
    logic [WSUM_W-1:0] w;
  } acc_word_t;

  localparam int ACC_WORD_W = 3 * ACC_W + WSUM_W;

endpackage

// ===== rtl/ftss_ram.sv =====
module ftss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ftss_offset.sv =====
module ftss_offset
  import ftss_pkg::*;
#(
  parameter int TABLE_WIDTH = 16
) (
  input  logic               clk,
  input  logic signed [21:0] delta,
  input  logic [15:0]        inv,
  output logic [$clog2(TABLE_WIDTH)-1:0] offset
);

  localparam int TW_B = $clog2(TABLE_WIDTH);

  logic [20:0] mag_r;
  logic [15:0] inv_r;
  logic [36:0] prod;
  logic [36+TW_B+1:0] scaled;

  always_ff @(posedge clk) begin
    mag_r <= delta[21] ? 21'(-delta) : delta[20:0];
    inv_r <= inv;
  end

  always_comb begin
    prod   = 37'(mag_r) * 37'(inv_r);
    scaled = (36+TW_B+2)'(prod) * (36+TW_B+2)'(TABLE_WIDTH);
  end

  always_ff @(posedge clk) begin
    if ((scaled >> 22) > (36+TW_B+2)'(TABLE_WIDTH - 1)) begin
      offset <= TW_B'(TABLE_WIDTH - 1);
    end else begin
      offset <= scaled[22 +: TW_B];
    end
  end

endmodule

// ===== rtl/ftss_mac.sv =====
module ftss_mac
  import ftss_pkg::*;
(
  input  logic               clk,
  input  logic signed [15:0] weight,
  input  logic [15:0]        imp,
  input  logic [15:0]        rad,
  input  logic [ACC_W-1:0]   acc,
  output logic [ACC_W-1:0]   sum
);

  logic signed [32:0] wi_r;
  logic [15:0]        rad_r;
  logic signed [49:0] prod;
  logic signed [49:0] total;

  always_ff @(posedge clk) begin
    wi_r  <= 33'(weight) * $signed({1'b0, imp});
    rad_r <= rad;
  end

  always_comb begin
    prod  = 50'(wi_r) * $signed({34'd0, rad_r});
    total = prod + 50'($signed(acc));
    if (total > 50'sh7FFFFFFFFFFF) begin
      sum = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (total < -50'sh800000000000) begin
      sum = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sum = total[ACC_W-1:0];
    end
  end

endmodule

// ===== rtl/film_tile_sample_splat.sv =====
// Load and ignored words are taken in the idle state; a read word's result is registered
// after the S_RD and S_OUT states. A sample walks its clipped footprint one pixel at a
// time, after S_SETUP and S_CLIP; each pixel passes S_PIX, S_OFF1, S_OFF2, S_TRD, S_ARD,
// S_MAC and S_WB for the table lookup and the read-modify-write on the accumulator RAM.
// No word is accepted while a result waits. After reset a clearing pass zeroes all
// TILE_PIXELS accumulators, accepting no word but taking configuration writes throughout.
module film_tile_sample_splat
  import ftss_pkg::*;
#(
  parameter int TABLE_WIDTH = 16,
  parameter int TILE_WIDTH  = 32,
  parameter int TILE_PIXELS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PA_W  = $clog2(TILE_PIXELS);
  localparam int TW_B  = $clog2(TABLE_WIDTH);
  localparam int ROWS  = TILE_PIXELS / TILE_WIDTH;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_CLIP, S_PIX, S_OFF1, S_OFF2, S_TRD, S_ARD,
    S_MAC, S_WB, S_RD, S_OUT
  } state_t;

  state_t state_r;

  logic [11:0] min_x_r, min_y_r;
  logic [12:0] max_x_r, max_y_r;
  logic [10:0] rad_x_r, rad_y_r;
  logic [15:0] inv_x_r, inv_y_r;

  in_word_t    item_r;
  logic signed [21:0] dx_r, dy_r;
  logic signed [15:0] x0_r, x1_r, y0_r, y1_r, x_r, y_r;
  logic [PA_W:0] clr_r;
  logic [PA_W-1:0] pa_r;
  logic          pa_ok_r;
  out_word_t     out_r;
  logic          out_v_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0; min_y_r <= '0;
      max_x_r <= 13'd32; max_y_r <= 13'd32;
      rad_x_r <= 11'd512; rad_y_r <= 11'd512;
      inv_x_r <= 16'd8192; inv_y_r <= 16'd8192;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_TILE_MIN_X: min_x_r <= cfg_data[11:0];
        REG_TILE_MIN_Y: min_y_r <= cfg_data[11:0];
        REG_TILE_MAX_X: max_x_r <= cfg_data[12:0];
        REG_TILE_MAX_Y: max_y_r <= cfg_data[12:0];
        REG_RADIUS_X:   rad_x_r <= cfg_data[10:0];
        REG_RADIUS_Y:   rad_y_r <= cfg_data[10:0];
        REG_INV_RAD_X:  inv_x_r <= cfg_data;
        REG_INV_RAD_Y:  inv_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_ready = (state_r == S_IDLE) && !out_v_r;
  assign in_acc   = in_valid && in_ready;

  logic [TW_B-1:0] fx, fy;
  ftss_offset #(.TABLE_WIDTH(TABLE_WIDTH)) u_offx (
    .clk(clk), .delta(22'($signed({x_r, 8'd0})) - dx_r), .inv(inv_x_r), .offset(fx));
  ftss_offset #(.TABLE_WIDTH(TABLE_WIDTH)) u_offy (
    .clk(clk), .delta(22'($signed({y_r, 8'd0})) - dy_r), .inv(inv_y_r), .offset(fy));

  logic [7:0]  t_raddr;
  logic [15:0] t_rdata;
  assign t_raddr = 8'((16'(fy) * 16'(TABLE_WIDTH)) + 16'(fx));
  ftss_ram #(.WIDTH(16), .DEPTH(TDEPTH)) u_table (
    .clk(clk), .we(in_acc && in_data.kind == KIND_LOAD),
    .waddr(in_data.table_index), .wdata(in_data.table_weight),
    .raddr(t_raddr), .rdata(t_rdata));

  logic            a_we;
  logic [PA_W-1:0] a_waddr, a_raddr;
  acc_word_t       a_wdata, a_rdata, a_new;
  ftss_ram #(.WIDTH(ACC_WORD_W), .DEPTH(TILE_PIXELS)) u_acc (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata));

  logic signed [15:0] w_r;
  ftss_mac u_mr (.clk(clk), .weight(w_r), .imp(item_r.importance_r),
    .rad(item_r.radiance_r), .acc(a_rdata.r), .sum(a_new.r));
  ftss_mac u_mg (.clk(clk), .weight(w_r), .imp(item_r.importance_g),
    .rad(item_r.radiance_g), .acc(a_rdata.g), .sum(a_new.g));
  ftss_mac u_mb (.clk(clk), .weight(w_r), .imp(item_r.importance_b),
    .rad(item_r.radiance_b), .acc(a_rdata.b), .sum(a_new.b));

  logic signed [32:0] wsum;
  logic signed [15:0] w_d_r;
  logic [WSUM_W-1:0]  w_new;
  always_comb begin
    wsum = 33'($signed(a_rdata.w)) + 33'(w_d_r);
    if (wsum > 33'sh07FFFFFFF) begin
      w_new = 32'h7FFFFFFF;
    end else if (wsum < -33'sh080000000) begin
      w_new = 32'h80000000;
    end else begin
      w_new = wsum[31:0];
    end
  end
  assign a_new.w = w_new;

  // Footprint bounds from the half-pixel shifted position, in whole pixels.
  logic signed [21:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [15:0] cx0, cx1, cy0, cy1;
  always_comb begin
    lo_x = dx_r - 22'(rad_x_r);
    lo_y = dy_r - 22'(rad_y_r);
    hi_x = dx_r + 22'(rad_x_r);
    hi_y = dy_r + 22'(rad_y_r);
    cx0 = 16'((lo_x + 22'sd255) >>> 8);
    cy0 = 16'((lo_y + 22'sd255) >>> 8);
    cx1 = 16'(hi_x >>> 8) + 16'sd1;
    cy1 = 16'(hi_y >>> 8) + 16'sd1;
  end

  logic signed [15:0] mx_lim, my_lim;
  assign mx_lim = 16'($signed({1'b0, min_x_r})) + 16'(TILE_WIDTH);
  assign my_lim = 16'($signed({1'b0, min_y_r})) + 16'(ROWS);

  logic [31:0] pidx;
  assign pidx = 32'(y_r - 16'($signed({1'b0, min_y_r}))) * 32'(TILE_WIDTH)
              + 32'(x_r - 16'($signed({1'b0, min_x_r})));

  always_comb begin
    a_we    = 1'b0;
    a_waddr = pa_r;
    a_wdata = a_new;
    a_raddr = pa_r;
    if (state_r == S_CLEAR) begin
      a_we    = 1'b1;
      a_waddr = clr_r[PA_W-1:0];
      a_wdata = '0;
    end else if (state_r == S_WB) begin
      a_we = pa_ok_r;
    end else if (state_r == S_IDLE) begin
      a_raddr = in_data.read_index[PA_W-1:0];
    end else if (state_r == S_RD) begin
      a_raddr = item_r.read_index[PA_W-1:0];
    end
  end

  logic rd_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (PA_W+1)'(TILE_PIXELS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            item_r  <= in_data;
            rd_ok_r <= 32'(in_data.read_index) < 32'(TILE_PIXELS);
            dx_r    <= 22'($signed({2'b0, in_data.sample_x})) - 22'sd128;
            dy_r    <= 22'($signed({2'b0, in_data.sample_y})) - 22'sd128;
            case (kind_t'(in_data.kind))
              KIND_SAMPLE: state_r <= S_SETUP;
              KIND_READ:   state_r <= S_RD;
              default:     state_r <= S_IDLE;
            endcase
          end
        end
        S_SETUP: begin
          x0_r <= cx0; x1_r <= cx1; y0_r <= cy0; y1_r <= cy1;
          state_r <= S_CLIP;
        end
        S_CLIP: begin
          if (x0_r < 16'($signed({1'b0, min_x_r}))) x0_r <= 16'($signed({1'b0, min_x_r}));
          if (y0_r < 16'($signed({1'b0, min_y_r}))) begin
            y0_r <= 16'($signed({1'b0, min_y_r}));
            y_r  <= 16'($signed({1'b0, min_y_r}));
          end else begin
            y_r <= y0_r;
          end
          if (x0_r < 16'($signed({1'b0, min_x_r}))) x_r <= 16'($signed({1'b0, min_x_r}));
          else x_r <= x0_r;
          x1_r <= (x1_r > 16'($signed({3'b0, max_x_r}))) ?
            ((16'($signed({3'b0, max_x_r})) > mx_lim) ? mx_lim : 16'($signed({3'b0, max_x_r})))
            : ((x1_r > mx_lim) ? mx_lim : x1_r);
          y1_r <= (y1_r > 16'($signed({3'b0, max_y_r}))) ?
            ((16'($signed({3'b0, max_y_r})) > my_lim) ? my_lim : 16'($signed({3'b0, max_y_r})))
            : ((y1_r > my_lim) ? my_lim : y1_r);
          state_r <= S_PIX;
        end
        S_PIX: begin
          if (y_r >= y1_r || x_r >= x1_r) begin
            state_r <= S_IDLE;
          end else begin
            pa_r    <= pidx[PA_W-1:0];
            pa_ok_r <= pidx < 32'(TILE_PIXELS);
            state_r <= S_OFF1;
          end
        end
        S_OFF1: state_r <= S_OFF2;
        S_OFF2: state_r <= S_TRD;
        S_TRD:  state_r <= S_ARD;
        S_ARD: begin
          w_r     <= t_rdata;
          state_r <= S_MAC;
        end
        S_MAC: begin
          w_d_r   <= w_r;
          state_r <= S_WB;
        end
        S_WB: begin
          if (x_r + 16'sd1 >= x1_r) begin
            x_r <= x0_r;
            y_r <= y_r + 16'sd1;
          end else begin
            x_r <= x_r + 16'sd1;
          end
          state_r <= S_PIX;
        end
        S_RD: state_r <= S_OUT;
        S_OUT: begin
          out_v_r <= 1'b1;
          if (rd_ok_r) begin
            out_r.sum_red      <= a_rdata.r;
            out_r.sum_green    <= a_rdata.g;
            out_r.sum_blue     <= a_rdata.b;
            out_r.weight_total <= a_rdata.w;
          end else begin
            out_r <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== tb/tb_film_tile_sample_splat.sv =====
module tb_film_tile_sample_splat
  import ftss_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_WIDTH = 16;
  localparam int TILE_WIDTH  = 32;
  localparam int TILE_PIXELS = 1024;
  localparam int SETTLE_CYCLES = 2500;
  localparam int IN_W = $bits(in_word_t);
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint WSUM_HI = 64'sd2147483647;
  localparam longint WSUM_LO = -WSUM_HI - 1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  film_tile_sample_splat #(
    .TABLE_WIDTH(TABLE_WIDTH),
    .TILE_WIDTH(TILE_WIDTH),
    .TILE_PIXELS(TILE_PIXELS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the tile state and registers.
  int unsigned tile_x0, tile_y0, tile_x1, tile_y1;
  int unsigned rad_x, rad_y, inv_x, inv_y;
  longint filter_tbl [TDEPTH];
  longint red_acc [TILE_PIXELS];
  longint green_acc [TILE_PIXELS];
  longint blue_acc [TILE_PIXELS];
  longint wsum_acc [TILE_PIXELS];

  out_word_t pixel_sums_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned table_step(longint pix, longint d, int unsigned inv);
    longint delta;
    longint f;
    delta = pix * 256 - d;
    if (delta < 0) delta = -delta;
    f = (delta * longint'(inv) * TABLE_WIDTH) >>> 22;
    return (f > TABLE_WIDTH - 1) ? TABLE_WIDTH - 1 : int'(f);
  endfunction

  task automatic splat_sample(in_word_t w);
    longint dx, dy, x0, x1, y0, y1, wt;
    longint tx0, ty0, tx1, ty1, rx, ry;
    int unsigned fx, fy, ta, pi;
    tx0 = longint'(tile_x0);
    ty0 = longint'(tile_y0);
    tx1 = longint'(tile_x1);
    ty1 = longint'(tile_y1);
    rx = longint'(rad_x);
    ry = longint'(rad_y);
    dx = longint'(w.sample_x) - 128;
    dy = longint'(w.sample_y) - 128;
    x0 = -((-(dx - rx)) >>> 8);
    y0 = -((-(dy - ry)) >>> 8);
    x1 = ((dx + rx) >>> 8) + 1;
    y1 = ((dy + ry) >>> 8) + 1;
    if (x0 < tx0) x0 = tx0;
    if (y0 < ty0) y0 = ty0;
    if (x1 > tx1) x1 = tx1;
    if (y1 > ty1) y1 = ty1;
    if (x1 > tx0 + TILE_WIDTH) x1 = tx0 + TILE_WIDTH;
    if (y1 > ty0 + TILE_PIXELS / TILE_WIDTH) y1 = ty0 + TILE_PIXELS / TILE_WIDTH;
    for (longint y = y0; y < y1; y++) begin
      fy = table_step(y, dy, inv_y);
      for (longint x = x0; x < x1; x++) begin
        fx = table_step(x, dx, inv_x);
        ta = (fy * TABLE_WIDTH + fx) % TDEPTH;
        wt = filter_tbl[ta];
        pi = int'((y - ty0) * TILE_WIDTH + (x - tx0));
        if (pi < TILE_PIXELS) begin
          red_acc[pi] = clip(red_acc[pi] + wt * w.importance_r * w.radiance_r, ACC_LO, ACC_HI);
          green_acc[pi] = clip(green_acc[pi] + wt * w.importance_g * w.radiance_g,
                               ACC_LO, ACC_HI);
          blue_acc[pi] = clip(blue_acc[pi] + wt * w.importance_b * w.radiance_b,
                              ACC_LO, ACC_HI);
          wsum_acc[pi] = clip(wsum_acc[pi] + wt, WSUM_LO, WSUM_HI);
        end
      end
    end
  endtask

  task automatic apply_word(in_word_t w);
    out_word_t e;
    case (kind_t'(w.kind))
      KIND_LOAD: filter_tbl[w.table_index] = longint'(w.table_weight);
      KIND_SAMPLE: splat_sample(w);
      KIND_READ: begin
        e = '0;
        if (w.read_index < TILE_PIXELS) begin
          e.sum_red = red_acc[w.read_index][47:0];
          e.sum_green = green_acc[w.read_index][47:0];
          e.sum_blue = blue_acc[w.read_index][47:0];
          e.weight_total = wsum_acc[w.read_index][31:0];
        end
        pixel_sums_q.push_back(e);
      end
      default: ;
    endcase
  endtask

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    apply_word(w);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pixel_sums_q.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          out_word_t e;
          e = pixel_sums_q.pop_front();
          if (out_data.sum_red !== e.sum_red) report("sum_red", out_data.sum_red, e.sum_red);
          if (out_data.sum_green !== e.sum_green)
            report("sum_green", out_data.sum_green, e.sum_green);
          if (out_data.sum_blue !== e.sum_blue)
            report("sum_blue", out_data.sum_blue, e.sum_blue);
          if (out_data.weight_total !== e.weight_total)
            report("weight_total", out_data.weight_total, e.weight_total);
        end
      end
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic drain;
    while (pixel_sums_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(int unsigned x0, int unsigned y0, int unsigned x1,
                            int unsigned y1, int unsigned rx, int unsigned ry,
                            int unsigned ix, int unsigned iy);
    logic [15:0] vals [8];
    vals = '{16'(x0), 16'(y0), 16'(x1), 16'(y1), 16'(rx), 16'(ry), 16'(ix), 16'(iy)};
    in_valid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (reg_idx_t'(i))
        REG_TILE_MIN_X: tile_x0 = vals[i] & 16'hFFF;
        REG_TILE_MIN_Y: tile_y0 = vals[i] & 16'hFFF;
        REG_TILE_MAX_X: tile_x1 = vals[i] & 16'h1FFF;
        REG_TILE_MAX_Y: tile_y1 = vals[i] & 16'h1FFF;
        REG_RADIUS_X: rad_x = vals[i] & 16'h7FF;
        REG_RADIUS_Y: rad_y = vals[i] & 16'h7FF;
        REG_INV_RAD_X: inv_x = vals[i];
        REG_INV_RAD_Y: inv_y = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t noise_word();
    in_word_t w;
    w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  function automatic in_word_t load_word(int unsigned idx, int unsigned val);
    in_word_t w;
    w = noise_word();
    w.kind = KIND_LOAD;
    w.table_index = 8'(idx);
    w.table_weight = 16'(val);
    return w;
  endfunction

  function automatic in_word_t read_word(int unsigned idx);
    in_word_t w;
    w = noise_word();
    w.kind = KIND_READ;
    w.read_index = 10'(idx);
    return w;
  endfunction

  function automatic in_word_t sample_word(longint sx, longint sy);
    in_word_t w;
    w = noise_word();
    w.kind = KIND_SAMPLE;
    w.sample_x = 20'(clip(sx, 0, 20'hFFFFF));
    w.sample_y = 20'(clip(sy, 0, 20'hFFFFF));
    return w;
  endfunction

  function automatic in_word_t random_word();
    int unsigned pick;
    longint span_x, span_y;
    pick = $urandom_range(99);
    span_x = (tile_x1 > tile_x0) ? clip(tile_x1 - tile_x0, 1, TILE_WIDTH) : 8;
    span_y = (tile_y1 > tile_y0) ? clip(tile_y1 - tile_y0, 1, TILE_WIDTH) : 8;
    if (pick < 10) return load_word($urandom_range(255), $urandom_range(65535));
    if (pick < 50) return read_word($urandom_range(1023));
    if (pick < 90)
      return sample_word(longint'(tile_x0) * 256 + $urandom_range(span_x * 256 + 1024) - 512,
                         longint'(tile_y0) * 256 + $urandom_range(span_y * 256 + 1024) - 512);
    if (pick < 94) begin
      in_word_t w;
      w = noise_word();
      w.kind = KIND_NONE;
      return w;
    end
    return noise_word();
  endfunction

  task automatic test_table_load;
    for (int i = 0; i < TDEPTH; i++)
      send_word(load_word(i, $urandom_range(65535)));
  endtask

  task automatic test_directed;
    send_word(load_word(0, 16'h7FFF));
    send_word(load_word(255, 16'h8000));
    send_word(load_word(1, 16'h0000));
    for (int i = 0; i < 2; i++) begin
      in_word_t w;
      w = sample_word(5 * 256 + 128, 7 * 256 + 128);
      {w.radiance_r, w.radiance_g, w.radiance_b} = '1;
      {w.importance_r, w.importance_g, w.importance_b} = '1;
      send_word(w);
    end
    send_word(read_word(7 * TILE_WIDTH + 5));
    send_word(read_word(7 * TILE_WIDTH + 6));
    send_word(sample_word(0, 0));
    send_word(sample_word(20'hFFFFF, 20'hFFFFF));
    send_word(sample_word(31 * 256 + 255, 31 * 256));
    send_word(read_word(0));
    send_word(read_word(1023));
    send_word(read_word(31));
    begin
      in_word_t w;
      w = noise_word();
      w.kind = KIND_NONE;
      send_word(w);
    end
    send_word(read_word(32));
  endtask

  task automatic test_tiny_tile;
    set_config(4095, 4095, 4096, 4096, 2047, 2047, 0, 0);
    send_word(sample_word(20'hFFFFF, 20'hFFFFF));
    send_word(sample_word(4095 * 256 + 128, 4095 * 256 + 128));
    send_word(sample_word(4094 * 256, 4094 * 256));
    send_word(read_word(0));
  endtask

  task automatic test_wide_tile;
    set_config(0, 0, 4096, 4096, 1000, 0, 65535, 65535);
    for (int i = 0; i < 6; i++)
      send_word(sample_word($urandom_range(40 * 256), $urandom_range(34 * 256)));
    for (int i = 0; i < 6; i++) send_word(read_word($urandom_range(1023)));
  endtask

  task automatic test_empty_tile;
    set_config(200, 100, 100, 50, 512, 512, 8192, 8192);
    for (int i = 0; i < 4; i++)
      send_word(sample_word(150 * 256 + $urandom_range(4096), 75 * 256 + $urandom_range(4096)));
    send_word(read_word(0));
  endtask

  task automatic test_backpressure;
    recv_hold <= 400;
    for (int i = 0; i < 12; i++) send_word(read_word($urandom_range(1023)));
    in_valid <= 1'b0;
    drain();
  endtask

  task automatic test_random(int n, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) send_word(random_word());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tile_x0 = 0;
    tile_y0 = 0;
    tile_x1 = 32;
    tile_y1 = 32;
    rad_x = 512;
    rad_y = 512;
    inv_x = 8192;
    inv_y = 8192;
    for (int i = 0; i < TDEPTH; i++) filter_tbl[i] = 0;
    for (int i = 0; i < TILE_PIXELS; i++) begin
      red_acc[i] = 0;
      green_acc[i] = 0;
      blue_acc[i] = 0;
      wsum_acc[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_table_load();
    test_directed();
    test_backpressure();
    test_tiny_tile();
    test_wide_tile();
    test_empty_tile();
    set_config(100, 50, 132, 82, 300, 200, 13981, 20971);
    test_random(32, 36, 63);
    set_config(10, 20, 30, 60, 128, 700, 32768, 5992);
    test_random(32, 63, 36);
    set_config(0, 0, 32, 32, 512, 512, 8192, 8192);
    test_random(32, 0, 0);

    in_valid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
